### hw/rtl/nmea_pkg.sv
// shared types and constants for the nmea sentence checker
package nmea_pkg;

    localparam logic [5:0] MAX_FIELDS = 6'd32;
    localparam logic [7:0] CHAR_MAX   = 8'd255;

    // phase codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_SUM1 = 3'd2;
    localparam logic [2:0] PH_SUM2 = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    // segment tags
    localparam logic [2:0] SEG_FRAME = 3'd0;
    localparam logic [2:0] SEG_TALK  = 3'd1;
    localparam logic [2:0] SEG_TYPE  = 3'd2;
    localparam logic [2:0] SEG_DATA  = 3'd3;
    localparam logic [2:0] SEG_SUM   = 3'd4;

    // framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] running_xor;
        logic [7:0] received_sum;
        logic       digit_bad;
        logic [5:0] field_count;
        logic [7:0] char_count;
    } state_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] segment;
        logic [5:0] field_index;
        logic [7:0] char_index;
        logic       sentence_end;
        logic       sentence_ok;
        logic       sum_match;
    } result_t;

endpackage

### hw/rtl/nmea_byte_decode.sv
// per-byte decode: tags one byte and computes the next framing state
module nmea_byte_decode (
    input  logic              [7:0] data_byte,
    input  logic                    check_enable,
    input  nmea_pkg::state_t        cur,
    output nmea_pkg::state_t        nxt,
    output nmea_pkg::result_t       res
);
    import nmea_pkg::*;

    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] char_bumped;
    logic       sum_valid;
    logic       match;

    // ascii hex digit to nibble
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte inside {[8'h30:8'h39]})
        begin
            hex_val = 4'(data_byte - 8'h30);
        end
        else if (data_byte inside {[8'h61:8'h66]})
        begin
            hex_val = 4'(data_byte - 8'h57);
        end
        else if (data_byte inside {[8'h41:8'h46]})
        begin
            hex_val = 4'(data_byte - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign char_bumped = (cur.char_count != CHAR_MAX) ? cur.char_count + 8'd1 : cur.char_count;
    assign sum_valid   = (cur.phase == PH_DONE) && !cur.digit_bad;
    assign match       = sum_valid && (cur.received_sum == cur.running_xor);

    always_comb
    begin
        nxt              = cur;
        res              = '0;
        res.byte_out     = data_byte;
        res.segment      = SEG_FRAME;
        if (data_byte == CH_DOLLAR)
        begin
            nxt       = '0;
            nxt.phase = PH_BODY;
        end
        else if (cur.phase == PH_IDLE)
        begin
            // outside a sentence: nothing tracked
        end
        else if (data_byte inside {CH_CR, CH_LF})
        begin
            res.sentence_end = 1'b1;
            res.sum_match    = match;
            res.sentence_ok  = !check_enable || match;
            res.field_index  = cur.field_count;
            res.char_index   = cur.char_count;
            nxt.phase        = PH_IDLE;
        end
        else if (cur.phase == PH_BODY)
        begin
            if (data_byte == CH_STAR)
            begin
                nxt.phase      = PH_SUM1;
                nxt.char_count = 8'd0;
            end
            else if (data_byte == CH_COMMA)
            begin
                nxt.running_xor = cur.running_xor ^ data_byte;
                if (cur.field_count < MAX_FIELDS)
                begin
                    nxt.field_count = cur.field_count + 6'd1;
                end
                nxt.char_count = 8'd0;
            end
            else
            begin
                nxt.running_xor = cur.running_xor ^ data_byte;
                nxt.char_count  = char_bumped;
                if (cur.field_count != 6'd0)
                begin
                    res.segment = SEG_DATA;
                end
                else if (cur.char_count < 8'd2)
                begin
                    res.segment = SEG_TALK;
                end
                else if (cur.char_count < 8'd5)
                begin
                    res.segment = SEG_TYPE;
                end
            end
            // framing and overlong address bytes report the updated count
            res.char_index  = (res.segment == SEG_FRAME) ? nxt.char_count : cur.char_count;
            res.field_index = nxt.field_count;
        end
        else
        begin
            if (hex_ok && (cur.phase == PH_SUM1 || cur.phase == PH_SUM2))
            begin
                nxt.received_sum = {cur.received_sum[3:0], hex_val};
                nxt.char_count   = char_bumped;
                nxt.phase        = (cur.phase == PH_SUM1) ? PH_SUM2 : PH_DONE;
                res.segment      = SEG_SUM;
            end
            else
            begin
                nxt.digit_bad = 1'b1;
            end
            res.char_index  = cur.char_count;
            res.field_index = cur.field_count;
        end
    end

endmodule

### hw/rtl/nmea_sentence_checker.sv
// nmea sentence checker top level: input register, byte decode, result register
// a byte passes from the input register through the decode into the result register
// throughput: one byte per cycle unless out_ready stalls; single registered decode stage
// the input and result registers advance together so ready stays high under flow
// reset clears the framing state, the pipeline valids and check_enable (0)
module nmea_sentence_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic [2:0] segment,
    output logic [5:0] field_index,
    output logic [7:0] char_index,
    output logic       sentence_end,
    output logic       sentence_ok,
    output logic       sum_match
);
    import nmea_pkg::*;

    logic       check_enable_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    logic       advance;

    // the result register can take a new beat when empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    nmea_byte_decode u_decode (
        .data_byte    (in_byte_reg),
        .check_enable (check_enable_reg),
        .cur          (state_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            check_enable_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
        end
        if (advance && in_valid_reg)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_out     = out_res_reg.byte_out;
    assign segment      = out_res_reg.segment;
    assign field_index  = out_res_reg.field_index;
    assign char_index   = out_res_reg.char_index;
    assign sentence_end = out_res_reg.sentence_end;
    assign sentence_ok  = out_res_reg.sentence_ok;
    assign sum_match    = out_res_reg.sum_match;

    // verdict flags only on a closing byte
    a_flags_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.sentence_end |-> !out_res_reg.sentence_ok
            && !out_res_reg.sum_match)
        else $error("verdict flag set on a non-closing byte");

    a_match_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.sum_match |-> out_res_reg.sentence_ok)
        else $error("checksum match without acceptance");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipeline");

    a_dollar_opens_body: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && in_byte_reg == CH_DOLLAR |=> state_reg.phase == PH_BODY)
        else $error("start byte did not open a sentence");

    a_field_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_count <= MAX_FIELDS)
        else $error("field count beyond its limit");

endmodule
